### rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the block buffer cache directory.
// ----------------------------------------------------------------------------
package bbc_pkg;

	localparam int ENTRIES    = 32;
	localparam int COUNT_BITS = 8;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ENTRY_W    = 5;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [1:0] {
		OP_GET     = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_MISS      = 2'd1,
		STAT_NOFREE    = 2'd2,
		STAT_UNDERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  device;
		logic [30:0] block_number;
		logic [4:0]  slot;
	} req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry;
		status_t            status;
		logic               needs_read;
	} res_t;

	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic [7:0]            dev;
		logic [30:0]           blk;
		logic [COUNT_BITS-1:0] cnt;
		logic                  vld;
	} ent_t;

	typedef struct packed {
		logic hit;
		logic free;
		logic sel;
	} flags_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_ALLOC,
		CELL_HIT,
		CELL_PIN,
		CELL_DEC
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

endpackage

### rtl/block_buffer_cache_lru_unit.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit
// Fully associative buffer directory kept as a chain of cells in recency
// order, with reference counts and least recently released replacement.
// ----------------------------------------------------------------------------
// a word accepted in idle is compared and its flags registered, then the
// cell chain is picked and updated and the result registered with done high;
// no new word is taken while busy. busy is high in the update cycle only.
// the receiver cannot stall: each result is shown for one cycle.
// reset clears all tags, counts and valid marks, order is entry 0 first.
module block_buffer_cache_lru_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bbc_pkg::req_t req,
	output logic          done,
	output bbc_pkg::res_t res
);

	localparam int N = bbc_pkg::ENTRIES;

	bbc_pkg::state_t      state_q, state_d;
	bbc_pkg::req_t        req_s1;
	logic [N-1:0]         hit_s1, free_s1, sel_s1;
	bbc_pkg::res_t        res_q, res_d;
	logic                 done_q;

	bbc_pkg::ent_t        ents [N];
	bbc_pkg::flags_t      flg  [N];
	bbc_pkg::ent_t        nbrs [N];
	bbc_pkg::cell_cmd_t   cmds [N];

	logic                 accept;
	logic [N-1:0]         hit_oh, free_oh, grab_oh, shift_mask;
	logic                 any_hit, any_free, any_sel;
	bbc_pkg::ent_t        grab;
	bbc_pkg::ent_t        tail;
	logic                 underflow, move_end;

	assign accept = start && (state_q == bbc_pkg::ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			bbc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bbc_pkg::ST_UPDATE;
				end
			end
			bbc_pkg::ST_UPDATE: begin
				busy    = 1'b1;
				state_d = bbc_pkg::ST_IDLE;
			end
			default: begin
				state_d = bbc_pkg::ST_IDLE;
			end
		endcase
	end

	// request word and compare flags
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			for (int p = 0; p < N; p++) begin
				hit_s1[p]  <= flg[p].hit;
				free_s1[p] <= flg[p].free;
				sel_s1[p]  <= flg[p].sel;
			end
		end
	end

	assign hit_oh   = hit_s1 & (~hit_s1 + N'(1));
	assign free_oh  = free_s1 & (~free_s1 + N'(1));
	assign any_hit  = |hit_s1;
	assign any_free = |free_s1;
	assign any_sel  = |sel_s1;

	always_comb begin
		if (req_s1.operation == bbc_pkg::OP_GET) begin
			grab_oh = any_hit ? hit_oh : free_oh;
		end else begin
			grab_oh = sel_s1;
		end
	end

	always_comb begin
		grab = '0;
		for (int p = 0; p < N; p++) begin
			grab = grab | ({$bits(bbc_pkg::ent_t){grab_oh[p]}} & ents[p]);
		end
	end

	assign underflow = ((req_s1.operation == bbc_pkg::OP_RELEASE) ||
	                    (req_s1.operation == bbc_pkg::OP_UNPIN)) &&
	                   any_sel && (grab.cnt == '0);
	assign move_end  = (req_s1.operation == bbc_pkg::OP_RELEASE) && any_sel &&
	                   (grab.cnt == bbc_pkg::COUNT_BITS'(1));
	assign shift_mask = move_end ? ~(sel_s1 - N'(1)) : '0;

	always_comb begin
		tail     = grab;
		tail.cnt = '0;
	end

	always_comb begin
		for (int p = 0; p < N; p++) begin
			cmds[p] = bbc_pkg::CELL_HOLD;
			if (state_q == bbc_pkg::ST_UPDATE) begin
				case (req_s1.operation)
					bbc_pkg::OP_GET: begin
						if (any_hit && hit_oh[p]) begin
							cmds[p] = bbc_pkg::CELL_HIT;
						end else if (!any_hit && free_oh[p]) begin
							cmds[p] = bbc_pkg::CELL_ALLOC;
						end
					end
					bbc_pkg::OP_PIN: begin
						if (sel_s1[p]) begin
							cmds[p] = bbc_pkg::CELL_PIN;
						end
					end
					default: begin
						if (!underflow) begin
							if (shift_mask[p]) begin
								cmds[p] = bbc_pkg::CELL_SHIFT;
							end else if (sel_s1[p]) begin
								cmds[p] = bbc_pkg::CELL_DEC;
							end
						end
					end
				endcase
			end
		end
	end

	// chain of cells, neighbour is the next more recent position
	for (genvar p = 0; p < N; p++) begin : g_cell
		if (p == N - 1) begin : g_last
			assign nbrs[p] = tail;
		end else begin : g_mid
			assign nbrs[p] = ents[p+1];
		end

		bbc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.init_idx (bbc_pkg::IDX_W'(p)),
			.cmd      (cmds[p]),
			.nbr      (nbrs[p]),
			.cmp_dev  (req.device),
			.cmp_blk  (req.block_number),
			.cmp_slot (req.slot),
			.new_dev  (req_s1.device),
			.new_blk  (req_s1.block_number),
			.ent      (ents[p]),
			.flags    (flg[p])
		);
	end

	// result word
	always_comb begin
		logic [31:0] grab_idx;
		grab_idx       = 32'(grab.idx);
		res_d.entry      = req_s1.slot;
		res_d.status     = bbc_pkg::STAT_DONE;
		res_d.needs_read = 1'b0;
		case (req_s1.operation)
			bbc_pkg::OP_GET: begin
				if (any_hit) begin
					res_d.entry      = grab_idx[bbc_pkg::ENTRY_W-1:0];
					res_d.needs_read = ~grab.vld;
				end else if (any_free) begin
					res_d.entry      = grab_idx[bbc_pkg::ENTRY_W-1:0];
					res_d.status     = bbc_pkg::STAT_MISS;
					res_d.needs_read = 1'b1;
				end else begin
					res_d.entry  = '0;
					res_d.status = bbc_pkg::STAT_NOFREE;
				end
			end
			default: begin
				if (underflow) begin
					res_d.status = bbc_pkg::STAT_UNDERFLOW;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == bbc_pkg::ST_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bbc_pkg::ST_UPDATE) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == bbc_pkg::ST_UPDATE))
		else $error("result word without an update cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 done)
		else $error("accepted word did not complete in two cycles");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbc_pkg::ST_UPDATE) |-> $onehot0(sel_s1))
		else $error("slot matches more than one cell");

	a_miss_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (res.status == bbc_pkg::STAT_MISS)) |-> res.needs_read)
		else $error("allocated entry without read request");
`endif

endmodule

### rtl/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell
// One position of the recency chain: holds an entry and its tag, count and
// valid mark, compares against a request and takes its neighbour's entry.
// ----------------------------------------------------------------------------
module bbc_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [bbc_pkg::IDX_W-1:0] init_idx,
	input  bbc_pkg::cell_cmd_t   cmd,
	input  bbc_pkg::ent_t        nbr,
	input  logic [7:0]           cmp_dev,
	input  logic [30:0]          cmp_blk,
	input  logic [4:0]           cmp_slot,
	input  logic [7:0]           new_dev,
	input  logic [30:0]          new_blk,
	output bbc_pkg::ent_t        ent,
	output bbc_pkg::flags_t      flags
);

	bbc_pkg::ent_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.idx <= init_idx;
			ent_q.dev <= '0;
			ent_q.blk <= '0;
			ent_q.cnt <= '0;
			ent_q.vld <= 1'b0;
		end else begin
			case (cmd)
				bbc_pkg::CELL_SHIFT: begin
					ent_q <= nbr;
				end
				bbc_pkg::CELL_ALLOC: begin
					ent_q.dev <= new_dev;
					ent_q.blk <= new_blk;
					ent_q.cnt <= bbc_pkg::COUNT_BITS'(1);
					ent_q.vld <= 1'b1;
				end
				bbc_pkg::CELL_HIT: begin
					if (ent_q.cnt != bbc_pkg::COUNT_MAX) begin
						ent_q.cnt <= ent_q.cnt + bbc_pkg::COUNT_BITS'(1);
					end
					ent_q.vld <= 1'b1;
				end
				bbc_pkg::CELL_PIN: begin
					if (ent_q.cnt != bbc_pkg::COUNT_MAX) begin
						ent_q.cnt <= ent_q.cnt + bbc_pkg::COUNT_BITS'(1);
					end
				end
				bbc_pkg::CELL_DEC: begin
					ent_q.cnt <= ent_q.cnt - bbc_pkg::COUNT_BITS'(1);
				end
				default: begin
					ent_q <= ent_q;
				end
			endcase
		end
	end

	assign ent        = ent_q;
	assign flags.hit  = (ent_q.dev == cmp_dev) && (ent_q.blk == cmp_blk);
	assign flags.free = (ent_q.cnt == '0);
	assign flags.sel  = (32'(ent_q.idx) == 32'(cmp_slot));

endmodule
